// ===== hw/rtl/rmrl_pkg.sv =====
// Shared types and constants for the routing message rate limiter.
// No dependencies; compile first.
package rmrl_pkg;

    // Message type codes
    localparam logic [7:0] MSG_REQUEST = 8'd1;
    localparam logic [7:0] MSG_REPLY   = 8'd2;
    localparam logic [7:0] MSG_ERROR   = 8'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W    = 2;
    localparam int         CFG_DATA_W   = 16;
    localparam logic [1:0] REG_LIMIT_EN = 2'd0;
    localparam logic [1:0] REG_REBOOT   = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;

    localparam logic [15:0] WINDOW_RESET = 16'd1000;

    // Drop cause codes
    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_REBOOT = 2'd1,
        CAUSE_RATE   = 2'd2
    } t_cause;

    // Per-log control from the top level
    typedef struct packed {
        logic rd;   // item accepted: fetch the oldest entry
        logic chk;  // item in check stage is limited by this log
    } t_log_ctl;

endpackage

// ===== hw/rtl/rmrl_in_if.sv =====
// Input channel of the routing message rate limiter: one message per item.
// No dependencies.
interface rmrl_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_type;
    logic [31:0] now_ms;
    logic        dest_is_broadcast;

    modport source (output valid, msg_type, now_ms, dest_is_broadcast, input ready);
    modport sink   (input valid, msg_type, now_ms, dest_is_broadcast, output ready);
endinterface

// ===== hw/rtl/rmrl_out_if.sv =====
// Output channel of the routing message rate limiter: one verdict per item.
// No dependencies.
interface rmrl_out_if;
    logic        valid;
    logic        ready;
    logic        allow_send;
    logic [1:0]  drop_cause;
    logic [31:0] last_broadcast_ms;

    modport source (output valid, allow_send, drop_cause, last_broadcast_ms, input ready);
    modport sink   (input valid, allow_send, drop_cause, last_broadcast_ms, output ready);
endinterface

// ===== hw/rtl/routing_message_rate_limiter.sv =====
// Routing message rate limiter. Each item on i_in is one outgoing routing
// message; each item on o_out is its verdict: allow_send, drop_cause and the
// time of the latest allowed broadcast after this message. Route replies are
// dropped while reboot_hold is set. With limit_enable set, requests and errors
// each keep a log of their last REQUEST_LIMIT / ERROR_LIMIT send times in a
// small synchronous memory; a full log drops a message whose oldest entry is
// younger than window_ms (age taken modulo 2^32). The block takes one item
// per cycle while o_out is ready. On acceptance the item enters the check
// stage and the oldest log entry is fetched from the memory into a register;
// when the check stage fires, it checks the age, writes the time back and
// loads the output register. A verdict waiting on o_out does not stop the
// next item from being fetched. No clearing pass is needed after reset: a
// log entry is only used once the log has filled.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while no item is in flight (not enforced by the block).
module routing_message_rate_limiter #(
    parameter int REQUEST_LIMIT = 10,
    parameter int ERROR_LIMIT   = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rmrl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rmrl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rmrl_in_if.sink                             i_in,
    rmrl_out_if.source                          o_out
);
    import rmrl_pkg::*;

    // Configuration registers
    logic        r_limit_en;
    logic        r_reboot;
    logic [15:0] r_window;

    // Check stage
    logic        r_s1_valid;
    logic [7:0]  r_s1_type;
    logic [31:0] r_s1_now;
    logic        r_s1_bcast;

    // Output register and broadcast time
    logic        r_out_valid;
    logic        r_out_allow;
    t_cause      r_out_cause;
    logic [31:0] r_bcast_time;

    logic        accept;
    logic        advance;
    logic        fire;
    logic        held;
    logic        is_req;
    logic        is_err;
    logic        req_admit;
    logic        err_admit;
    logic        allow;
    t_cause      cause;
    logic [31:0] n_bcast_time;
    t_log_ctl    req_ctl;
    t_log_ctl    err_ctl;

    // Handshake: the check stage advances when the output register is free
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        held   = r_reboot && (r_s1_type == MSG_REPLY);
        is_req = r_limit_en && (r_s1_type == MSG_REQUEST);
        is_err = r_limit_en && (r_s1_type == MSG_ERROR);

        req_ctl.rd  = accept;
        req_ctl.chk = fire && is_req;
        err_ctl.rd  = accept;
        err_ctl.chk = fire && is_err;

        allow = 1'b1;
        cause = CAUSE_NONE;
        if (held) begin
            allow = 1'b0;
            cause = CAUSE_REBOOT;
        end else if (is_req && !req_admit) begin
            allow = 1'b0;
            cause = CAUSE_RATE;
        end else if (is_err && !err_admit) begin
            allow = 1'b0;
            cause = CAUSE_RATE;
        end

        n_bcast_time = (allow && r_s1_bcast) ? r_s1_now : r_bcast_time;
    end

    rmrl_log_unit #(.LIMIT(REQUEST_LIMIT)) u_req_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (req_ctl),
        .i_now    (r_s1_now),
        .i_window (r_window),
        .o_admit  (req_admit)
    );

    rmrl_log_unit #(.LIMIT(ERROR_LIMIT)) u_err_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (err_ctl),
        .i_now    (r_s1_now),
        .i_window (r_window),
        .o_admit  (err_admit)
    );

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en <= 1'b0;
            r_reboot   <= 1'b0;
            r_window   <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LIMIT_EN: r_limit_en <= i_cfg_data[0];
                REG_REBOOT:   r_reboot   <= i_cfg_data[0];
                REG_WINDOW:   r_window   <= i_cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bcast_time <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_bcast_time <= n_bcast_time;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the item in the check stage, load the verdict on fire
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_type  <= i_in.msg_type;
            r_s1_now   <= i_in.now_ms;
            r_s1_bcast <= i_in.dest_is_broadcast;
        end
        if (fire) begin
            r_out_allow <= allow;
            r_out_cause <= cause;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.allow_send        = r_out_allow;
    assign o_out.drop_cause        = r_out_cause;
    assign o_out.last_broadcast_ms = r_bcast_time;

endmodule

// ===== hw/rtl/rmrl_log_unit.sv =====
// One sliding-window send log: time memory, fill count, oldest pointer.
// Depends on rmrl_pkg.
module rmrl_log_unit #(
    parameter int LIMIT = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmrl_pkg::t_log_ctl i_ctl,
    input  logic [31:0]       i_now,
    input  logic [15:0]       i_window,
    output logic              o_admit
);
    import rmrl_pkg::*;

    localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int CNT_W = $clog2(LIMIT + 1);

    logic [31:0]      mem [LIMIT];
    logic [31:0]      r_rd_data;
    logic             r_fwd;
    logic [31:0]      r_fwd_data;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_oldest, n_oldest;

    logic             full;
    logic [31:0]      entry;
    logic [31:0]      age;
    logic             wr;
    logic [IDX_W-1:0] wr_addr;

    always_comb begin
        full    = (r_count >= CNT_W'(LIMIT));
        entry   = r_fwd ? r_fwd_data : r_rd_data;
        age     = i_now - entry;
        o_admit = !full || (age >= {16'd0, i_window});
        wr      = i_ctl.chk && o_admit;
        wr_addr = full ? r_oldest : r_count[IDX_W-1:0];
        n_count  = r_count;
        n_oldest = r_oldest;
        if (wr && full) begin
            n_oldest = (r_oldest == IDX_W'(LIMIT - 1)) ? '0 : r_oldest + 1'b1;
        end else if (wr) begin
            n_count = r_count + 1'b1;
        end
    end

    // Memory: write the logged time, read the next oldest entry on accept
    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[wr_addr] <= i_now;
        end
        if (i_ctl.rd) begin
            r_rd_data  <= mem[n_oldest];
            r_fwd_data <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_fwd    <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_oldest <= n_oldest;
            // Bypass the memory when the entry being fetched is written now
            if (i_ctl.rd) begin
                r_fwd <= wr && (wr_addr == n_oldest);
            end
        end
    end

endmodule
